/* rtl/rks_pkg.sv */
// shared types for the record key sorter
package rks_pkg;
	typedef struct packed {
		logic [15:0] record_index;
		logic [63:0] sort_key;
		logic        batch_last;
	} rks_in_t;

	typedef struct packed {
		logic [15:0] out_index;
		logic [63:0] out_key;
		logic        out_last;
		logic        overflowed;
	} rks_out_t;

	typedef struct packed {
		logic [15:0] index;
		logic [63:0] key;
	} rks_rec_t;

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EMIT} rks_state_t;
endpackage

/* rtl/rks_mem.sv */
// record memory: one write port, one registered read port
module rks_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rks_pkg::rks_rec_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output rks_pkg::rks_rec_t rdata
);
	rks_pkg::rks_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/record_key_sorter.sv */
// record key sorter top level: load, scan for maximum, emit
// Loads a batch of records (index plus 64-bit key) over the in channel, one
// transfer per cycle while in_ready is high. The transfer with batch_last set
// ends loading; the block then emits every held record in descending key
// order on the out channel, equal keys in arrival order, out_last on the
// final one. Records beyond MAX_RECORDS are dropped and overflowed is set on
// every result of that batch.
// cfg_we/cfg_wdata write key_is_signed (0 unsigned, 1 two's complement); the
// value at the batch_last transfer orders the batch.
// Search: each held record is found by a full pass over the record memory
// (one read per cycle through the registered read port), so a batch of n
// held records takes n passes after loading.
// in_ready stays low during the output phase. A stalled receiver holds the
// result in the output register until the transfer. Reset empties the batch
// and clears key_is_signed; memory contents are not cleared.
module record_key_sorter #(
	parameter int MAX_RECORDS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rks_pkg::rks_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rks_pkg::rks_out_t   out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);

	rks_pkg::rks_state_t state_q, state_d;
	logic            cfg_signed_q, sort_signed_q, ovf_q;
	logic [CW-1:0]   cnt_q, rd_ptr_q, emit_q;
	logic            last_vld_q;
	logic [63:0]     last_key_q;
	logic [AW-1:0]   last_addr_q;
	logic            valid_s1;
	logic [AW-1:0]   addr_s1;
	logic            best_vld_q;
	logic [AW-1:0]   best_addr_q;
	rks_pkg::rks_rec_t best_q, rd_rec, wr_rec;
	logic            in_xfer, out_xfer, wr_en, rd_en, better, cand, scan_end;
	logic [63:0]     rd_ord, best_ord, last_ord;

	assign in_ready = (state_q == rks_pkg::ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign out_valid = (state_q == rks_pkg::ST_EMIT);
	assign out_xfer = out_valid && out_ready;
	assign wr_en    = in_xfer && (cnt_q < CW'(MAX_RECORDS));
	assign wr_rec   = '{index: in_data.record_index, key: in_data.sort_key};
	assign rd_en    = (state_q == rks_pkg::ST_SCAN) && (rd_ptr_q < cnt_q);

	rks_mem #(.DEPTH(MAX_RECORDS), .AW(AW)) u_mem (
		.clk(clk), .we(wr_en), .waddr(cnt_q[AW-1:0]), .wdata(wr_rec),
		.re(rd_en), .raddr(rd_ptr_q[AW-1:0]), .rdata(rd_rec)
	);

	// flip sign bit so signed order becomes unsigned order
	assign rd_ord   = rd_rec.key ^ {sort_signed_q, 63'b0};
	assign best_ord = best_q.key ^ {sort_signed_q, 63'b0};
	assign last_ord = last_key_q ^ {sort_signed_q, 63'b0};
	// still unsent: lower key than the last sent one, or equal key at a later address
	assign cand     = !last_vld_q || (rd_ord < last_ord) ||
		((rd_ord == last_ord) && (addr_s1 > last_addr_q));
	assign better   = valid_s1 && cand && (!best_vld_q || rd_ord > best_ord);
	assign scan_end = valid_s1 && (CW'(addr_s1) == cnt_q - CW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rks_pkg::ST_LOAD: if (in_xfer && in_data.batch_last) state_d = rks_pkg::ST_SCAN;
			rks_pkg::ST_SCAN: if (scan_end) state_d = rks_pkg::ST_EMIT;
			rks_pkg::ST_EMIT: begin
				if (out_xfer) begin
					state_d = ((emit_q + CW'(1)) == cnt_q) ? rks_pkg::ST_LOAD : rks_pkg::ST_SCAN;
				end
			end
			default: state_d = rks_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rks_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_signed_q  <= 1'b0;
			sort_signed_q <= 1'b0;
			ovf_q         <= 1'b0;
			cnt_q         <= '0;
			rd_ptr_q      <= '0;
			emit_q        <= '0;
			last_vld_q    <= 1'b0;
			valid_s1      <= 1'b0;
			best_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_signed_q <= cfg_wdata;
			end
			valid_s1 <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (better) begin
				best_vld_q <= 1'b1;
			end
			if (in_xfer) begin
				if (wr_en) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (in_data.batch_last) begin
					sort_signed_q <= cfg_signed_q;
					rd_ptr_q      <= '0;
					best_vld_q    <= 1'b0;
				end
			end
			if (out_xfer) begin
				rd_ptr_q   <= '0;
				best_vld_q <= 1'b0;
				if ((emit_q + CW'(1)) == cnt_q) begin
					cnt_q      <= '0;
					emit_q     <= '0;
					ovf_q      <= 1'b0;
					last_vld_q <= 1'b0;
				end else begin
					emit_q     <= emit_q + CW'(1);
					last_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_ptr_q[AW-1:0];
		if (better) begin
			best_q      <= rd_rec;
			best_addr_q <= addr_s1;
		end
		if (out_xfer) begin
			last_key_q  <= best_q.key;
			last_addr_q <= best_addr_q;
		end
	end

	assign out_data = '{out_index: best_q.index, out_key: best_q.key,
		out_last: (emit_q + CW'(1)) == cnt_q, overflowed: ovf_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RECORDS)) else $error("held count beyond capacity");
	a_emit_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_vld_q) else $error("emitting without a found record");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (emit_q < cnt_q)) else $error("emit count beyond held count");
	a_no_read_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_en) else $error("memory read while loading");
endmodule

/* tb/record_key_sorter_tb.sv */
// testbench for the record key sorter: batch stimulus, sorted-order prediction and checking
`timescale 1ns / 100ps

module record_key_sorter_tb;
	localparam int CAPACITY = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rks_pkg::rks_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rks_pkg::rks_out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	// predictor state
	logic key_is_signed_q = 1'b0;
	logic [63:0] pending_keys [$];
	logic [15:0] pending_ids [$];
	logic batch_dropped = 1'b0;
	rks_pkg::rks_out_t sorted_expected [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold_cycles = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int result_total = 0;

	record_key_sorter #(.MAX_RECORDS(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] order_key(input logic [63:0] k);
		return key_is_signed_q ? {~k[63], k[62:0]} : k;
	endfunction

	// store one record; on the last one, emit the stable descending order
	task automatic predict_record(input rks_pkg::rks_in_t rec);
		logic [63:0] keys [$];
		logic [15:0] ids [$];
		logic [63:0] k;
		logic [15:0] id;
		int j;
		rks_pkg::rks_out_t res;
		if (pending_keys.size() < CAPACITY) begin
			pending_keys.push_back(rec.sort_key);
			pending_ids.push_back(rec.record_index);
		end else begin
			batch_dropped = 1'b1;
		end
		if (rec.batch_last) begin
			keys = pending_keys;
			ids = pending_ids;
			for (int i = 1; i < keys.size(); i++) begin
				k = keys[i];
				id = ids[i];
				j = i;
				while (j > 0 && order_key(keys[j-1]) < order_key(k)) begin
					keys[j] = keys[j-1];
					ids[j] = ids[j-1];
					j--;
				end
				keys[j] = k;
				ids[j] = id;
			end
			for (int i = 0; i < keys.size(); i++) begin
				res.out_index = ids[i];
				res.out_key = keys[i];
				res.out_last = (i == keys.size() - 1);
				res.overflowed = batch_dropped;
				sorted_expected.push_back(res);
			end
			pending_keys.delete();
			pending_ids.delete();
			batch_dropped = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// valid stays high into the next transfer; gaps and drains drop it
	task automatic send_record(input logic [15:0] id, input logic [63:0] key,
			input logic last);
		rks_pkg::rks_in_t rec;
		rec.record_index = id;
		rec.sort_key = key;
		rec.batch_last = last;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rec;
		do
			@(posedge clk);
		while (!in_ready);
		predict_record(rec);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_expected.size() != 0)
			@(posedge clk);
		repeat (CAPACITY * 3) @(posedge clk);
	endtask

	task automatic write_signed_mode(input logic val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_is_signed_q = val;
	endtask

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		case ($urandom_range(7))
			0: k = 64'h0;
			1: k = '1;
			2: k = 64'h8000_0000_0000_0000;
			3: k = 64'h7fff_ffff_ffff_ffff;
			4: k = {60'h0, k[3:0]}; // small keys give many ties
			default: ;
		endcase
		return k;
	endfunction

	task automatic send_batch(input int n);
		for (int i = 0; i < n; i++)
			send_record(16'($urandom), random_key(), i == n - 1);
	endtask

	// extremes, ties, and single-record batches in both compare modes
	task automatic test_directed();
		for (int m = 0; m < 2; m++) begin
			write_signed_mode(m[0]);
			send_record(16'h0000, 64'h0, 1'b0);
			send_record(16'hffff, '1, 1'b0);
			send_record(16'h1234, 64'h8000_0000_0000_0000, 1'b0);
			send_record(16'h4321, 64'h7fff_ffff_ffff_ffff, 1'b0);
			send_record(16'h0005, 64'h5, 1'b0);
			send_record(16'h0006, 64'h5, 1'b0);
			send_record(16'h0007, 64'h5, 1'b1);
			send_record(16'haaaa, 64'h5555_aaaa_5555_aaaa, 1'b1);
		end
	endtask

	// fill past capacity, dropped last record included
	task automatic test_overflow();
		send_batch(CAPACITY);
		send_batch(CAPACITY + 3);
	endtask

	// mode change mid batch: the value at the last record rules
	task automatic test_mode_in_batch();
		write_signed_mode(1'b0);
		send_record(16'h0001, 64'hffff_0000_0000_0000, 1'b0);
		send_record(16'h0002, 64'h1, 1'b0);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_wdata <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_is_signed_q = 1'b1;
		send_record(16'h0003, 64'h8000_0000_0000_0001, 1'b1);
	endtask

	// receiver holds off long while the sender stalls on the next batch, then sender waits for drain
	task automatic test_backpressure();
		recv_hold_cycles = 400;
		send_batch(20);
		send_batch(10);
		wait_drained();
		send_batch(5);
	endtask

	task automatic test_random(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 2, 30)
				: $urandom_range(8, 1);
			if ($urandom_range(5) == 0)
				write_signed_mode(1'($urandom_range(1)));
			send_batch(n);
			sent += n;
		end
	endtask

	// receiver side: random stall plus the long hold-off
	always @(posedge clk) begin
		if (recv_hold_cycles > 0) begin
			recv_hold_cycles <= recv_hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		rks_pkg::rks_out_t want;
		if (arst_n && out_valid && out_ready) begin
			result_total++;
			if (sorted_expected.size() == 0) begin
				report_mismatch("unexpected result", out_data.out_key, 64'h0);
			end else begin
				want = sorted_expected.pop_front();
				if (out_data.out_index !== want.out_index)
					report_mismatch("out_index", 64'(out_data.out_index),
						64'(want.out_index));
				if (out_data.out_key !== want.out_key)
					report_mismatch("out_key", out_data.out_key, want.out_key);
				if (out_data.out_last !== want.out_last)
					report_mismatch("out_last", 64'(out_data.out_last),
						64'(want.out_last));
				if (out_data.overflowed !== want.overflowed)
					report_mismatch("overflowed", 64'(out_data.overflowed),
						64'(want.overflowed));
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("record_key_sorter verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 33;
		recv_idle_pct = 47;
		test_overflow();
		test_mode_in_batch();
		test_backpressure();
		test_random(25);
		send_idle_pct = 47;
		recv_idle_pct = 33;
		test_random(25);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(25);
		wait_drained();
		if (mismatch_count == 0)
			$display("record_key_sorter verification clean");
		else
			$display("record_key_sorter verification failed");
		$finish;
	end
endmodule
